[src/conv3x3_grey_edge_replicate_core_assert.svh]
// ----------------------------------------------------------------------------
// conv3x3 grey edge replicate core assertion macros
// Concurrent checks on the filter's internal control; compiled out with
// ASSERT_OFF.
// ----------------------------------------------------------------------------
`ifndef CONV3X3_GREY_EDGE_REPLICATE_CORE_ASSERT_SVH
`define CONV3X3_GREY_EDGE_REPLICATE_CORE_ASSERT_SVH
`ifndef ASSERT_OFF
`define C3GER_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("c3ger: same-cycle check failed");
`define C3GER_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("c3ger: next-cycle check failed");
`else
`define C3GER_ASSERT_IMP(label, clk, rst, ante, cons)
`define C3GER_ASSERT_NXT(label, clk, rst, ante, cons)
`endif
`endif

[src/c3ger_pkg.sv]
// ----------------------------------------------------------------------------
// c3ger_pkg
// Sizes, register codes and item types shared by the 3x3 filter files.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package c3ger_pkg;

   localparam int MAX_WIDTH  = 1024;
   localparam int MAX_HEIGHT = 1024;
   localparam int COL_W      = $clog2(MAX_WIDTH);
   localparam int ROW_W      = $clog2(MAX_HEIGHT);
   localparam int IROW_W     = 16;
   localparam int CMP_W      = 17;
   localparam int SIZE_W     = 11;
   localparam int KROW_W     = 24;
   localparam int PIX_W      = 8;
   localparam int POS_W      = 10;
   localparam int TAPS       = 9;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 24;

   localparam logic [SIZE_W-1:0] WIDTH_RESET  = SIZE_W'(1024);
   localparam logic [SIZE_W-1:0] HEIGHT_RESET = SIZE_W'(1024);
   localparam logic [KROW_W-1:0] KTOP_RESET   = KROW_W'(0);
   localparam logic [KROW_W-1:0] KMID_RESET   = KROW_W'(256);
   localparam logic [KROW_W-1:0] KBOT_RESET   = KROW_W'(0);

   localparam logic MODE_FLUSH = 1'b1;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_IMAGE_WIDTH       = 3'd0,
      CSR_IMAGE_HEIGHT      = 3'd1,
      CSR_KERNEL_ROW_TOP    = 3'd2,
      CSR_KERNEL_ROW_MIDDLE = 3'd3,
      CSR_KERNEL_ROW_BOTTOM = 3'd4
   } csr_idx_type;

   typedef logic [PIX_W-1:0]  pix_type;
   typedef pix_type [TAPS-1:0] win_type;
   typedef logic [KROW_W-1:0] krow_type;
   typedef krow_type [2:0]    kern_type;

   typedef struct packed {
      logic    mode;
      pix_type pixel_in;
   } req_type;

   typedef struct packed {
      pix_type              pixel_out;
      logic [POS_W-1:0]     out_col;
      logic [POS_W-1:0]     out_row;
      logic                 frame_last;
   } rsp_type;

   typedef struct packed {
      logic                 en;
      logic [COL_W-1:0]     addr;
      logic [2*PIX_W-1:0]   data;
   } ram_wr_type;

   typedef struct packed {
      logic [POS_W-1:0]     col;
      logic [POS_W-1:0]     row;
      logic                 last;
   } pos_type;

endpackage

`default_nettype wire

[src/c3ger_line_ram.sv]
// ----------------------------------------------------------------------------
// c3ger_line_ram
// Paired line store: upper row in the high byte, lower row in the low byte.
// One write and one registered read per cycle, write data forwarded on a
// same-address read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module c3ger_line_ram (
   input  logic                                   clock,
   input  c3ger_pkg::ram_wr_type                  wr,
   input  logic [c3ger_pkg::COL_W-1:0]            rd_addr,
   output logic [2*c3ger_pkg::PIX_W-1:0]          rd_data
);

   logic [2*c3ger_pkg::PIX_W-1:0] line_mem_ff [c3ger_pkg::MAX_WIDTH];
   logic [2*c3ger_pkg::PIX_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         line_mem_ff[wr.addr] <= wr.data;
      end
      if (wr.en && (wr.addr == rd_addr)) begin
         rd_data_ff <= wr.data;
      end else begin
         rd_data_ff <= line_mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

[src/c3ger_mac.sv]
// ----------------------------------------------------------------------------
// c3ger_mac
// Nine-tap weighted sum of a clamped window, kept modulo 256.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module c3ger_mac (
   input  c3ger_pkg::win_type  taps,
   input  c3ger_pkg::kern_type kern,
   output c3ger_pkg::pix_type  pixel_out
);

   localparam int PIX_W = c3ger_pkg::PIX_W;

   logic [2*PIX_W-1:0] prod [c3ger_pkg::TAPS];
   c3ger_pkg::pix_type acc;

   // low byte of a signed product equals the low byte of the unsigned one
   always_comb begin
      for (int r = 0; r < 3; r++) begin
         for (int c = 0; c < 3; c++) begin
            prod[r*3+c] = (2*PIX_W)'(taps[r*3+c]) *
                          (2*PIX_W)'(kern[r][c*PIX_W +: PIX_W]);
         end
      end
      acc = '0;
      for (int k = 0; k < c3ger_pkg::TAPS; k++) begin
         acc = acc + prod[k][PIX_W-1:0];
      end
   end

   assign pixel_out = acc;

endmodule

`default_nettype wire

[src/conv3x3_grey_edge_replicate_core.sv]
// ----------------------------------------------------------------------------
// conv3x3_grey_edge_replicate_core
// 3x3 greyscale filter with clamp-to-edge borders over a raster stream.
//
// Input channel req_*: one item per pixel in raster order (mode 0), then
// width+1 flush items (mode 1) to drain the last row. A flush item that
// arrives while source pixels are still due is taken and dropped.
// Result channel rsp_*: filtered pixel with its column, row and a frame-last
// flag. The result for pixel (r, c) is caused by the item for (r+1, c+1).
// Throughput: one item per clock while req_ready is high, set by the
// single-port-pair line store that is read one column ahead and written on
// each item that is not dropped. A result passes the window and tap register,
// then the multiply-add into the result register, before it shows on rsp_valid.
// Stall: the tap stage and the result register form a two-entry queue; req_ready
// drops only when both hold a result and rsp_ready is low.
// Config csr_*: write only while idle; sizes 0 act as 1, above 1024 as 1024.
// Reset: synchronous; config, counters, window and valid flags return to reset values.
// Line store content is undefined after reset; clamps hide unwritten entries.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "conv3x3_grey_edge_replicate_core_assert.svh"

module conv3x3_grey_edge_replicate_core (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  c3ger_pkg::req_type                   req_data,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output c3ger_pkg::rsp_type                   rsp_data,
   input  logic                                 csr_we,
   input  logic [c3ger_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [c3ger_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   localparam int CMP_W  = c3ger_pkg::CMP_W;
   localparam int COL_W  = c3ger_pkg::COL_W;
   localparam int ROW_W  = c3ger_pkg::ROW_W;
   localparam int IROW_W = c3ger_pkg::IROW_W;
   localparam int SIZE_W = c3ger_pkg::SIZE_W;
   localparam int KROW_W = c3ger_pkg::KROW_W;
   localparam int POS_W  = c3ger_pkg::POS_W;
   localparam int PIX_W  = c3ger_pkg::PIX_W;

   logic [SIZE_W-1:0]      width_ff;
   logic [SIZE_W-1:0]      height_ff;
   c3ger_pkg::kern_type    kern_ff;

   c3ger_pkg::win_type     window_ff, window_in;
   logic [COL_W-1:0]       input_col_ff, input_col_in;
   logic [IROW_W-1:0]      input_row_ff, input_row_in;
   logic [COL_W-1:0]       output_col_ff, output_col_in;
   logic [ROW_W-1:0]       output_row_ff, output_row_in;

   logic                   s1_vld_ff, s1_vld_in;
   c3ger_pkg::win_type     taps_ff, taps_in;
   c3ger_pkg::pos_type     pos_ff, pos_in;
   logic                   rsp_vld_ff, rsp_vld_in;
   c3ger_pkg::rsp_type     rsp_ff;

   logic [CMP_W-1:0]       w_eff, h_eff, ic_ext, ir_ext, oc_ext, or_ext;
   logic                   accept, act, draining, flush, emit;
   logic                   col_end, row_last, col_last, last, rsp_adv;
   c3ger_pkg::pix_type [2:0] col_new;
   logic [2*PIX_W-1:0]     rd_pair;
   c3ger_pkg::ram_wr_type  ram_wr;
   c3ger_pkg::pix_type     mac_pixel;
   int                     sr, sc;

   always_comb begin
      if (width_ff == '0) begin
         w_eff = CMP_W'(1);
      end else if (CMP_W'(width_ff) > CMP_W'(c3ger_pkg::MAX_WIDTH)) begin
         w_eff = CMP_W'(c3ger_pkg::MAX_WIDTH);
      end else begin
         w_eff = CMP_W'(width_ff);
      end
      if (height_ff == '0) begin
         h_eff = CMP_W'(1);
      end else if (CMP_W'(height_ff) > CMP_W'(c3ger_pkg::MAX_HEIGHT)) begin
         h_eff = CMP_W'(c3ger_pkg::MAX_HEIGHT);
      end else begin
         h_eff = CMP_W'(height_ff);
      end
   end

   assign rsp_adv   = !rsp_vld_ff || rsp_ready;
   assign req_ready = !s1_vld_ff || rsp_adv;

   always_comb begin
      ic_ext   = CMP_W'(input_col_ff);
      ir_ext   = CMP_W'(input_row_ff);
      oc_ext   = CMP_W'(output_col_ff);
      or_ext   = CMP_W'(output_row_ff);
      accept   = req_valid && req_ready;
      draining = ir_ext >= h_eff;
      flush    = req_data.mode == c3ger_pkg::MODE_FLUSH;
      act      = accept && !(flush && !draining);

      col_new[0] = rd_pair[2*PIX_W-1:PIX_W];
      col_new[1] = rd_pair[PIX_W-1:0];
      col_new[2] = draining ? '0 : req_data.pixel_in;

      window_in = window_ff;
      if (act) begin
         for (int r = 0; r < 3; r++) begin
            window_in[r*3]   = window_ff[r*3+1];
            window_in[r*3+1] = window_ff[r*3+2];
            window_in[r*3+2] = col_new[r];
         end
      end

      emit     = act && ((ir_ext >= CMP_W'(2)) ||
                         ((ir_ext == CMP_W'(1)) && (ic_ext >= CMP_W'(1))));
      col_end  = (ic_ext + CMP_W'(1)) >= w_eff;
      row_last = (or_ext + CMP_W'(1)) >= h_eff;
      col_last = (oc_ext + CMP_W'(1)) >= w_eff;
      last     = row_last && col_last;

      input_col_in  = input_col_ff;
      input_row_in  = input_row_ff;
      output_col_in = output_col_ff;
      output_row_in = output_row_ff;
      if (act) begin
         if (col_end) begin
            input_col_in = '0;
            if (input_row_ff != '1) begin
               input_row_in = input_row_ff + 1'b1;
            end
         end else begin
            input_col_in = input_col_ff + 1'b1;
         end
      end
      if (emit) begin
         if (last) begin
            input_col_in  = '0;
            input_row_in  = '0;
            output_col_in = '0;
            output_row_in = '0;
         end else if (col_last) begin
            output_col_in = '0;
            output_row_in = output_row_ff + 1'b1;
         end else begin
            output_col_in = output_col_ff + 1'b1;
         end
      end

      // replicate the centre row or column at the image edges
      for (int r = 0; r < 3; r++) begin
         for (int c = 0; c < 3; c++) begin
            sr = r;
            sc = c;
            if (r == 0 && output_row_ff == '0) sr = 1;
            if (r == 2 && row_last) sr = 1;
            if (c == 0 && output_col_ff == '0) sc = 1;
            if (c == 2 && col_last) sc = 1;
            taps_in[r*3+c] = window_in[sr*3+sc];
         end
      end

      pos_in.col  = POS_W'(output_col_ff);
      pos_in.row  = POS_W'(output_row_ff);
      pos_in.last = last;

      ram_wr.en   = act;
      ram_wr.addr = input_col_ff;
      ram_wr.data = {col_new[1], col_new[2]};

      if (emit) begin
         s1_vld_in = 1'b1;
      end else if (rsp_adv) begin
         s1_vld_in = 1'b0;
      end else begin
         s1_vld_in = s1_vld_ff;
      end
      rsp_vld_in = rsp_adv ? s1_vld_ff : rsp_vld_ff;
   end

   c3ger_line_ram u_line_ram (
      .clock   (clock),
      .wr      (ram_wr),
      .rd_addr (input_col_in),
      .rd_data (rd_pair)
   );

   c3ger_mac u_mac (
      .taps      (taps_ff),
      .kern      (kern_ff),
      .pixel_out (mac_pixel)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff      <= c3ger_pkg::WIDTH_RESET;
         height_ff     <= c3ger_pkg::HEIGHT_RESET;
         kern_ff[0]    <= c3ger_pkg::KTOP_RESET;
         kern_ff[1]    <= c3ger_pkg::KMID_RESET;
         kern_ff[2]    <= c3ger_pkg::KBOT_RESET;
         window_ff     <= '0;
         input_col_ff  <= '0;
         input_row_ff  <= '0;
         output_col_ff <= '0;
         output_row_ff <= '0;
         s1_vld_ff     <= 1'b0;
         rsp_vld_ff    <= 1'b0;
      end else begin
         if (csr_we) begin
            unique case (csr_index)
               c3ger_pkg::CSR_IMAGE_WIDTH:       width_ff   <= csr_wdata[SIZE_W-1:0];
               c3ger_pkg::CSR_IMAGE_HEIGHT:      height_ff  <= csr_wdata[SIZE_W-1:0];
               c3ger_pkg::CSR_KERNEL_ROW_TOP:    kern_ff[0] <= csr_wdata[KROW_W-1:0];
               c3ger_pkg::CSR_KERNEL_ROW_MIDDLE: kern_ff[1] <= csr_wdata[KROW_W-1:0];
               c3ger_pkg::CSR_KERNEL_ROW_BOTTOM: kern_ff[2] <= csr_wdata[KROW_W-1:0];
               default: ;
            endcase
         end
         window_ff     <= window_in;
         input_col_ff  <= input_col_in;
         input_row_ff  <= input_row_in;
         output_col_ff <= output_col_in;
         output_row_ff <= output_row_in;
         s1_vld_ff     <= s1_vld_in;
         rsp_vld_ff    <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         taps_ff <= taps_in;
         pos_ff  <= pos_in;
      end
      if (rsp_adv && s1_vld_ff) begin
         rsp_ff.pixel_out  <= mac_pixel;
         rsp_ff.out_col    <= pos_ff.col;
         rsp_ff.out_row    <= pos_ff.row;
         rsp_ff.frame_last <= pos_ff.last;
      end
   end

   assign rsp_valid = rsp_vld_ff;
   assign rsp_data  = rsp_ff;

   `C3GER_ASSERT_IMP(a_full_blocks_req, clock, reset,
      s1_vld_ff && rsp_vld_ff && !rsp_ready, !req_ready)
   `C3GER_ASSERT_NXT(a_emit_fills_stage, clock, reset, emit, s1_vld_ff)
   `C3GER_ASSERT_NXT(a_last_clears_pos, clock, reset, emit && last,
      input_col_ff == '0 && input_row_ff == '0 && output_col_ff == '0 && output_row_ff == '0)
   `C3GER_ASSERT_NXT(a_drop_holds_state, clock, reset, accept && !act,
      $stable(input_col_ff) && $stable(input_row_ff) && $stable(window_ff))

endmodule

`default_nettype wire

[tb/conv3x3_grey_edge_replicate_core_test.sv]
// ----------------------------------------------------------------------------
// conv3x3_grey_edge_replicate_core_test
// Drives raster frames of grey pixels and flush items into the 3x3 filter,
// predicts every filtered pixel with an independent model of the window,
// line stores and clamp-to-edge borders, and checks each result in order. A short directed
// table comes first, then the widest row under one long stall and the tallest frame, then
// random frames under random sizes and kernels, with random gaps on both channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module conv3x3_grey_edge_replicate_core_test;
   import c3ger_pkg::*;

   localparam logic        MODE_PIXEL     = 1'b0;
   localparam int unsigned RANDOM_ITEMS   = 1100;
   localparam int unsigned SETTLE_CYCLES  = 8;
   localparam int unsigned SQUEEZE_CYCLES = 400;
   localparam int unsigned RUN_LIMIT      = 1000000;
   localparam int unsigned TAIL_LIMIT     = 2000;

   typedef enum {ROW_CFG, ROW_ITEM} row_kind_type;

   typedef struct {
      row_kind_type kind;
      csr_idx_type  idx;
      logic [23:0]  value;
      req_type      item;
      bit           typed;
      rsp_type      want;
   } row_type;

   typedef struct {
      bit      typed;
      rsp_type want;
   } key_type;

   logic                  clock;
   logic                  reset     = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   req_type               req_data  = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   rsp_type               rsp_data;
   logic                  csr_we    = 1'b0;
   csr_idx_type           csr_index = CSR_IMAGE_WIDTH;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   conv3x3_grey_edge_replicate_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // filter model state
   logic [SIZE_W-1:0] cfg_width;
   logic [SIZE_W-1:0] cfg_height;
   krow_type          cfg_kern [3];
   pix_type           store_up [MAX_WIDTH];
   pix_type           store_lo [MAX_WIDTH];
   pix_type           nbhd [TAPS];
   int unsigned       in_col, in_row, pos_col, pos_row;

   key_type     answer_key [$];
   rsp_type     due_pixels [$];
   int unsigned errors          = 0;
   int unsigned items_taken     = 0;
   int unsigned results_checked = 0;
   int unsigned frames_seen     = 0;
   int unsigned held_off        = 0;
   int unsigned widest          = 0;
   int unsigned tallest         = 0;
   int unsigned fed             = 0;
   int unsigned cycle_count     = 0;
   bit          sender_calm     = 1'b0;
   bit          receiver_calm   = 1'b0;
   bit          squeeze_req     = 1'b0;

   row_type plan [28] = '{
      '{ROW_CFG,  CSR_IMAGE_WIDTH,       24'd2,      '{MODE_PIXEL, 8'h00}, 1'b0, '0},
      '{ROW_CFG,  CSR_IMAGE_HEIGHT,      24'd2,      '{MODE_PIXEL, 8'h00}, 1'b0, '0},
      '{ROW_ITEM, CSR_IMAGE_WIDTH,       24'd0,      '{MODE_PIXEL, 8'h00}, 1'b0, '0},
      '{ROW_ITEM, CSR_IMAGE_WIDTH,       24'd0,      '{MODE_FLUSH, 8'h5A}, 1'b0, '0},
      '{ROW_ITEM, CSR_IMAGE_WIDTH,       24'd0,      '{MODE_PIXEL, 8'hFF}, 1'b0, '0},
      '{ROW_ITEM, CSR_IMAGE_WIDTH,       24'd0,      '{MODE_PIXEL, 8'h80}, 1'b0, '0},
      '{ROW_ITEM, CSR_IMAGE_WIDTH,       24'd0,      '{MODE_PIXEL, 8'h7F}, 1'b1,
        '{8'h00, 10'd0, 10'd0, 1'b0}},
      '{ROW_ITEM, CSR_IMAGE_WIDTH,       24'd0,      '{MODE_PIXEL, 8'h55}, 1'b1,
        '{8'hFF, 10'd1, 10'd0, 1'b0}},
      '{ROW_ITEM, CSR_IMAGE_WIDTH,       24'd0,      '{MODE_FLUSH, 8'h00}, 1'b1,
        '{8'h80, 10'd0, 10'd1, 1'b0}},
      '{ROW_ITEM, CSR_IMAGE_WIDTH,       24'd0,      '{MODE_FLUSH, 8'h00}, 1'b1,
        '{8'h7F, 10'd1, 10'd1, 1'b1}},
      '{ROW_ITEM, CSR_IMAGE_WIDTH,       24'd0,      '{MODE_FLUSH, 8'hA5}, 1'b0, '0},
      '{ROW_CFG,  CSR_IMAGE_WIDTH,       24'd0,      '{MODE_PIXEL, 8'h00}, 1'b0, '0},
      '{ROW_CFG,  CSR_IMAGE_HEIGHT,      24'd0,      '{MODE_PIXEL, 8'h00}, 1'b0, '0},
      '{ROW_CFG,  CSR_KERNEL_ROW_TOP,    24'h808080, '{MODE_PIXEL, 8'h00}, 1'b0, '0},
      '{ROW_CFG,  CSR_KERNEL_ROW_MIDDLE, 24'h7F7F7F, '{MODE_PIXEL, 8'h00}, 1'b0, '0},
      '{ROW_CFG,  CSR_KERNEL_ROW_BOTTOM, 24'hFFFFFF, '{MODE_PIXEL, 8'h00}, 1'b0, '0},
      '{ROW_ITEM, CSR_IMAGE_WIDTH,       24'd0,      '{MODE_PIXEL, 8'hFF}, 1'b0, '0},
      '{ROW_ITEM, CSR_IMAGE_WIDTH,       24'd0,      '{MODE_FLUSH, 8'h00}, 1'b0, '0},
      '{ROW_ITEM, CSR_IMAGE_WIDTH,       24'd0,      '{MODE_FLUSH, 8'hFF}, 1'b0, '0},
      '{ROW_CFG,  CSR_IMAGE_WIDTH,       24'd3,      '{MODE_PIXEL, 8'h00}, 1'b0, '0},
      '{ROW_CFG,  CSR_IMAGE_HEIGHT,      24'd1,      '{MODE_PIXEL, 8'h00}, 1'b0, '0},
      '{ROW_ITEM, CSR_IMAGE_WIDTH,       24'd0,      '{MODE_PIXEL, 8'h01}, 1'b0, '0},
      '{ROW_ITEM, CSR_IMAGE_WIDTH,       24'd0,      '{MODE_PIXEL, 8'hFE}, 1'b0, '0},
      '{ROW_ITEM, CSR_IMAGE_WIDTH,       24'd0,      '{MODE_PIXEL, 8'h10}, 1'b0, '0},
      '{ROW_ITEM, CSR_IMAGE_WIDTH,       24'd0,      '{MODE_FLUSH, 8'h00}, 1'b0, '0},
      '{ROW_ITEM, CSR_IMAGE_WIDTH,       24'd0,      '{MODE_PIXEL, 8'hC3}, 1'b0, '0},
      '{ROW_ITEM, CSR_IMAGE_WIDTH,       24'd0,      '{MODE_FLUSH, 8'h00}, 1'b0, '0},
      '{ROW_ITEM, CSR_IMAGE_WIDTH,       24'd0,      '{MODE_FLUSH, 8'h00}, 1'b0, '0}
   };

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic int unsigned eff_size(input logic [SIZE_W-1:0] v,
                                            input int unsigned maxv);
      if (v == 0) return 1;
      if (int'(v) > maxv) return maxv;
      return v;
   endfunction

   task automatic model_reset();
      cfg_width   = WIDTH_RESET;
      cfg_height  = HEIGHT_RESET;
      cfg_kern[0] = KTOP_RESET;
      cfg_kern[1] = KMID_RESET;
      cfg_kern[2] = KBOT_RESET;
      foreach (store_up[i]) begin
         store_up[i] = '0;
         store_lo[i] = '0;
      end
      foreach (nbhd[i]) nbhd[i] = '0;
      in_col  = 0;
      in_row  = 0;
      pos_col = 0;
      pos_row = 0;
   endtask

   task automatic filter_step(input req_type item, output bit made, output rsp_type res);
      int unsigned w, h, ic, ir, sr, sc;
      bit          draining;
      pix_type     column [3];
      int          sum;
      made     = 1'b0;
      res      = '0;
      w        = eff_size(cfg_width, MAX_WIDTH);
      h        = eff_size(cfg_height, MAX_HEIGHT);
      draining = (in_row >= h);
      // drop a flush that comes while source pixels are still due
      if (item.mode == MODE_FLUSH && !draining) return;
      ic = (in_col >= MAX_WIDTH) ? 0 : in_col;
      ir = in_row;
      column[0] = store_up[ic];
      column[1] = store_lo[ic];
      column[2] = draining ? '0 : item.pixel_in;
      for (int r = 0; r < 3; r++) begin
         nbhd[r*3]     = nbhd[r*3 + 1];
         nbhd[r*3 + 1] = nbhd[r*3 + 2];
         nbhd[r*3 + 2] = column[r];
      end
      store_up[ic] = column[1];
      store_lo[ic] = column[2];
      if (ic + 1 >= w) begin
         in_col = 0;
         if (in_row < 32'hFFFF) in_row++;
      end else begin
         in_col = ic + 1;
      end
      if (!((ir >= 2) || (ir == 1 && ic >= 1))) return;
      sum = 0;
      for (int r = 0; r < 3; r++) begin
         for (int c = 0; c < 3; c++) begin
            sr = r;
            sc = c;
            if (r == 0 && pos_row == 0) sr = 1;
            if (r == 2 && pos_row + 1 >= h) sr = 1;
            if (c == 0 && pos_col == 0) sc = 1;
            if (c == 2 && pos_col + 1 >= w) sc = 1;
            sum += int'(nbhd[sr*3 + sc]) * int'(byte'(cfg_kern[r][8*c +: 8]));
         end
      end
      res.pixel_out  = sum[7:0];
      res.out_col    = POS_W'(pos_col);
      res.out_row    = POS_W'(pos_row);
      res.frame_last = (pos_row + 1 >= h) && (pos_col + 1 >= w);
      if (res.frame_last) begin
         in_col  = 0;
         in_row  = 0;
         pos_col = 0;
         pos_row = 0;
      end else if (pos_col + 1 >= w) begin
         pos_col = 0;
         pos_row++;
      end else begin
         pos_col++;
      end
      made = 1'b1;
   endtask

   function automatic void flag_field(input string name, input int unsigned want,
                                      input int unsigned got);
      if (want != got) begin
         errors++;
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      end
   endfunction

   always @(posedge clock) begin : watch
      key_type key;
      rsp_type guess;
      rsp_type want;
      bit      made;
      if (!reset) begin
         if (csr_we) begin
            case (csr_index)
               CSR_IMAGE_WIDTH:       cfg_width   = csr_wdata[SIZE_W-1:0];
               CSR_IMAGE_HEIGHT:      cfg_height  = csr_wdata[SIZE_W-1:0];
               CSR_KERNEL_ROW_TOP:    cfg_kern[0] = csr_wdata[KROW_W-1:0];
               CSR_KERNEL_ROW_MIDDLE: cfg_kern[1] = csr_wdata[KROW_W-1:0];
               CSR_KERNEL_ROW_BOTTOM: cfg_kern[2] = csr_wdata[KROW_W-1:0];
               default: ;
            endcase
         end
         if (req_valid && !req_ready) held_off++;
         if (req_valid && req_ready) begin
            items_taken++;
            key = answer_key.pop_front();
            filter_step(req_data, made, guess);
            if (key.typed) due_pixels.push_back(key.want);
            else if (made) due_pixels.push_back(guess);
         end
         if (rsp_valid && rsp_ready) begin
            results_checked++;
            if (rsp_data.frame_last) frames_seen++;
            if (due_pixels.size() == 0) begin
               errors++;
               $display("%0t: unexpected result, expected none, actual %h", $time, rsp_data);
            end else begin
               want = due_pixels.pop_front();
               flag_field("pixel_out", want.pixel_out, rsp_data.pixel_out);
               flag_field("out_col", want.out_col, rsp_data.out_col);
               flag_field("out_row", want.out_row, rsp_data.out_row);
               flag_field("frame_last", want.frame_last, rsp_data.frame_last);
            end
         end
      end
   end

   initial begin : result_sink
      int unsigned hold;
      while (reset) @(posedge clock);
      forever begin
         hold = receiver_calm ? 0 : $urandom_range(19);
         if (squeeze_req) begin
            squeeze_req = 1'b0;
            hold        = SQUEEZE_CYCLES;
         end
         if (hold > 0) begin
            rsp_ready <= 1'b0;
            repeat (hold) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!(rsp_valid && rsp_ready));
      end
   end

   initial begin : watchdog
      while (cycle_count < RUN_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("status: fail");
      $finish;
   end

   function automatic pix_type pix_draw();
      case ($urandom_range(7))
         0:       return 8'h00;
         1:       return 8'hFF;
         default: return pix_type'($urandom_range(255));
      endcase
   endfunction

   function automatic krow_type kernel_draw();
      case ($urandom_range(5))
         0:       return 24'hFFFFFF;
         1:       return 24'h808080;
         2:       return 24'h7F7F7F;
         3:       return 24'h000000;
         default: return krow_type'($urandom);
      endcase
   endfunction

   task automatic offer_item(input logic mode, input pix_type px, input bit typed,
                             input rsp_type want);
      int unsigned gap;
      gap = sender_calm ? 0 : $urandom_range(19);
      csr_we <= 1'b0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      answer_key.push_back('{typed, want});
      req_valid <= 1'b1;
      req_data  <= '{mode: mode, pixel_in: px};
      do @(posedge clock); while (!(req_valid && req_ready));
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      csr_we    <= 1'b0;
      @(posedge clock);
      while (answer_key.size() != 0 || due_pixels.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input csr_idx_type idx, input logic [CSR_DATA_W-1:0] value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
   endtask

   task automatic program_phase(input logic [SIZE_W-1:0] w, input logic [SIZE_W-1:0] h);
      settle();
      csr_write(CSR_IMAGE_WIDTH, CSR_DATA_W'(w));
      csr_write(CSR_IMAGE_HEIGHT, CSR_DATA_W'(h));
      csr_write(CSR_KERNEL_ROW_TOP, kernel_draw());
      csr_write(CSR_KERNEL_ROW_MIDDLE, kernel_draw());
      csr_write(CSR_KERNEL_ROW_BOTTOM, kernel_draw());
   endtask

   task automatic run_frame(input logic [SIZE_W-1:0] w_reg, input logic [SIZE_W-1:0] h_reg,
                            input bit retune);
      int unsigned w, h, total;
      w     = eff_size(w_reg, MAX_WIDTH);
      h     = eff_size(h_reg, MAX_HEIGHT);
      total = w * h;
      if (w > widest) widest = w;
      if (h > tallest) tallest = h;
      for (int unsigned p = 0; p < total; p++) begin
         if ($urandom_range(9) == 0) offer_item(MODE_FLUSH, pix_draw(), 1'b0, '0);
         if (retune && p == total / 2) begin
            settle();
            case ($urandom_range(2))
               0:       csr_write(CSR_KERNEL_ROW_TOP, kernel_draw());
               1:       csr_write(CSR_KERNEL_ROW_MIDDLE, kernel_draw());
               default: csr_write(CSR_KERNEL_ROW_BOTTOM, kernel_draw());
            endcase
         end
         offer_item(MODE_PIXEL, pix_draw(), 1'b0, '0);
         fed++;
      end
      for (int unsigned d = 0; d <= w; d++) begin
         offer_item(($urandom_range(3) == 0) ? MODE_PIXEL : MODE_FLUSH, pix_draw(), 1'b0, '0);
         fed++;
      end
      if ($urandom_range(3) == 0) offer_item(MODE_FLUSH, pix_draw(), 1'b0, '0);
   endtask

   initial begin : stimulus
      logic [SIZE_W-1:0] w_reg, h_reg;
      int unsigned       frames;
      model_reset();
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      foreach (plan[i]) begin
         if (plan[i].kind == ROW_CFG) begin
            settle();
            csr_write(plan[i].idx, plan[i].value);
         end else begin
            offer_item(plan[i].item.mode, plan[i].item.pixel_in, plan[i].typed, plan[i].want);
         end
      end

      // widest row with a long receiver stall, then the tallest frame
      program_phase(11'd2047, 11'd1);
      squeeze_req = 1'b1;
      run_frame(11'd2047, 11'd1, 1'b0);
      program_phase(11'd0, 11'd2047);
      run_frame(11'd0, 11'd2047, 1'b0);

      fed = 0;
      while (fed < RANDOM_ITEMS) begin
         sender_calm   = ($urandom_range(3) == 0);
         receiver_calm = ($urandom_range(3) == 0);
         case ($urandom_range(9))
            0:       w_reg = 11'd0;
            1:       w_reg = 11'd1;
            2:       w_reg = 11'd2;
            default: w_reg = SIZE_W'($urandom_range(3, 12));
         endcase
         case ($urandom_range(9))
            0:       h_reg = 11'd0;
            1:       h_reg = 11'd1;
            default: h_reg = SIZE_W'($urandom_range(2, 6));
         endcase
         program_phase(w_reg, h_reg);
         frames = $urandom_range(1, 3);
         repeat (frames) run_frame(w_reg, h_reg, ($urandom_range(4) == 0));
      end

      req_valid <= 1'b0;
      csr_we    <= 1'b0;
      for (int unsigned n = 0; n < TAIL_LIMIT && due_pixels.size() != 0; n++)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (due_pixels.size() != 0) begin
         errors++;
         $display("%0t: %0d results expected, actual none", $time, due_pixels.size());
      end

      $display("covered %0d items, %0d results checked over %0d frames",
               items_taken, results_checked, frames_seen);
      $display("rows up to %0d pixels, frames up to %0d rows, input stalled %0d cycles",
               widest, tallest, held_off);
      if (errors == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

[files.f]
+incdir+src
src/c3ger_pkg.sv
src/c3ger_line_ram.sv
src/c3ger_mac.sv
src/conv3x3_grey_edge_replicate_core.sv
tb/conv3x3_grey_edge_replicate_core_test.sv
